FILE: hdl/message_substring_filter_core_assert.svh
`ifndef MESSAGE_SUBSTRING_FILTER_CORE_ASSERT_SVH
`define MESSAGE_SUBSTRING_FILTER_CORE_ASSERT_SVH

// Same-cycle implication, checked out of reset
`define MSF_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("msf: same-cycle check failed");

// Next-cycle implication, checked out of reset
`define MSF_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("msf: next-cycle check failed");

`endif

FILE: hdl/msf_pkg.sv
package msf_pkg;

    localparam int MAX_PATTERN_DEF = 16;
    localparam int TYPE_COUNT_DEF  = 32;

    localparam int PAT_BYTES = 16;
    localparam int LEN_W     = 5;
    localparam int TYPE_W    = 5;
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 64;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_TYPE_MASK      = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LO     = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_HI     = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_PATTERN_LENGTH = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CASE_SENSITIVE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_GREY_OUT       = 3'd5;

    typedef struct packed {
        logic [7:0]        text_byte;
        logic              byte_valid;
        logic              end_of_message;
        logic [TYPE_W-1:0] msg_type;
    } s_payload_t;

    typedef struct packed {
        logic visible;
        logic greyed_out;
    } m_payload_t;

    typedef logic [PAT_BYTES-1:0][7:0] pattern_t;

    // common control fanned out along the cell row
    typedef struct packed {
        logic             shift;
        logic             clear;
        logic             case_sensitive;
        logic [LEN_W-1:0] len;
    } cell_ctrl_t;

endpackage

FILE: hdl/msf_cell.sv
module msf_cell #(
    parameter int INDEX = 0
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  msf_pkg::cell_ctrl_t  ctrl,
    input  msf_pkg::pattern_t    pattern,
    input  logic [7:0]           byte_in,
    input  logic                 filled_in,
    output logic [7:0]           byte_out,
    output logic                 filled_out,
    output logic                 ok
);

    logic [7:0]                     byte_reg;
    logic                           filled_reg;
    logic                           filled_next;
    logic [msf_pkg::LEN_W-1:0]      pat_idx;
    logic                           in_use;
    logic [7:0]                     pat_byte;

    function automatic logic [7:0] fold(input logic [7:0] c, input logic cs);
        logic [7:0] r;
        r = c;
        if (!cs && c >= 8'h41 && c <= 8'h5A) begin
            r = c + 8'h20;
        end
        return r;
    endfunction

    // this cell holds window byte INDEX, lined up against pattern byte len-1-INDEX
    assign in_use   = msf_pkg::LEN_W'(INDEX) < ctrl.len;
    assign pat_idx  = ctrl.len - msf_pkg::LEN_W'(INDEX) - msf_pkg::LEN_W'(1);
    assign pat_byte = pattern[pat_idx[3:0]];

    // compare the byte this cell takes on the shift
    assign ok = !in_use
             || (filled_in && (fold(byte_in, ctrl.case_sensitive)
                               == fold(pat_byte, ctrl.case_sensitive)));

    always_comb begin
        filled_next = filled_reg;
        if (ctrl.clear) begin
            filled_next = 1'b0;
        end else if (ctrl.shift) begin
            filled_next = filled_in;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            filled_reg <= 1'b0;
        end else begin
            filled_reg <= filled_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (ctrl.shift) begin
            byte_reg <= byte_in;
        end
    end

    assign byte_out   = byte_reg;
    assign filled_out = filled_reg;

endmodule

FILE: hdl/message_substring_filter_core.sv
// Channel  | Ports                          | Beat
// ---------+--------------------------------+-------------------------------------
// input    | s_valid s_ready s_payload      | one text byte, end mark, msg type
// result   | m_valid m_ready m_payload      | visible / greyed_out at message end
// config   | cfg_we cfg_index cfg_data      | one register write, no wait
//
// One beat a cycle while s_ready is high: the byte enters cell 0 of MAX_PATTERN cells
// and each cell in use compares its next byte to its pattern byte in that same cycle.
// The result is registered; a new beat is taken while it waits unless m_ready is low.
// Synchronous active-low reset clears the fill marks, found flag and result valid, and
// returns the config registers to their defaults; window bytes and result payload are
// not reset.
`include "message_substring_filter_core_assert.svh"

module message_substring_filter_core #(
    parameter int MAX_PATTERN = msf_pkg::MAX_PATTERN_DEF,
    parameter int TYPE_COUNT  = msf_pkg::TYPE_COUNT_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  msf_pkg::s_payload_t               s_payload,
    output logic                              m_valid,
    input  logic                              m_ready,
    output msf_pkg::m_payload_t               m_payload,
    input  logic                              cfg_we,
    input  logic [msf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [msf_pkg::CFG_DATA_W-1:0]    cfg_data
);

    logic [TYPE_COUNT-1:0]         type_mask_reg;
    logic [63:0]                   pattern_lo_reg;
    logic [63:0]                   pattern_hi_reg;
    logic [msf_pkg::LEN_W-1:0]     pattern_length_reg;
    logic                          case_sensitive_reg;
    logic                          grey_out_reg;

    logic                          found_reg;
    logic                          m_valid_reg;
    msf_pkg::m_payload_t           m_payload_reg;

    logic                          s_accept;
    logic [msf_pkg::LEN_W-1:0]     eff_len;
    msf_pkg::cell_ctrl_t           ctrl;
    msf_pkg::pattern_t             pattern;
    logic [7:0]                    byte_chain   [MAX_PATTERN:0];
    logic                          filled_chain [MAX_PATTERN:0];
    logic [MAX_PATTERN-1:0]        ok_vec;
    logic                          hit;
    logic                          found_next;
    logic                          type_pass;
    logic                          filtered;
    msf_pkg::m_payload_t           m_payload_next;

    assign s_ready  = !m_valid_reg || m_ready;
    assign s_accept = s_valid && s_ready;

    // clamp length to the row
    assign eff_len = (pattern_length_reg > msf_pkg::LEN_W'(MAX_PATTERN))
                   ? msf_pkg::LEN_W'(MAX_PATTERN) : pattern_length_reg;

    assign pattern = {pattern_hi_reg, pattern_lo_reg};

    assign ctrl.shift          = s_accept && s_payload.byte_valid;
    assign ctrl.clear          = s_accept && s_payload.end_of_message;
    assign ctrl.case_sensitive = case_sensitive_reg;
    assign ctrl.len            = eff_len;

    assign byte_chain[0]   = s_payload.text_byte;
    assign filled_chain[0] = 1'b1;

    for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
        msf_cell #(
            .INDEX (k)
        ) u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .ctrl       (ctrl),
            .pattern    (pattern),
            .byte_in    (byte_chain[k]),
            .filled_in  (filled_chain[k]),
            .byte_out   (byte_chain[k+1]),
            .filled_out (filled_chain[k+1]),
            .ok         (ok_vec[k])
        );
    end

    assign hit        = ctrl.shift && (eff_len != '0) && (&ok_vec);
    assign found_next = found_reg || hit;

    always_comb begin
        type_pass = 1'b0;
        for (int i = 0; i < TYPE_COUNT; i++) begin
            if (s_payload.msg_type == msf_pkg::TYPE_W'(i)) begin
                type_pass = type_mask_reg[i];
            end
        end
    end

    assign filtered = !type_pass || ((eff_len != '0) && !found_next);

    always_comb begin
        m_payload_next.visible    = !filtered || grey_out_reg;
        m_payload_next.greyed_out = filtered && grey_out_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            type_mask_reg      <= '1;
            pattern_lo_reg     <= '0;
            pattern_hi_reg     <= '0;
            pattern_length_reg <= '0;
            case_sensitive_reg <= 1'b0;
            grey_out_reg       <= 1'b0;
        end else if (cfg_we) begin
            case (cfg_index)
                msf_pkg::REG_TYPE_MASK:      type_mask_reg      <= cfg_data[TYPE_COUNT-1:0];
                msf_pkg::REG_PATTERN_LO:     pattern_lo_reg     <= cfg_data;
                msf_pkg::REG_PATTERN_HI:     pattern_hi_reg     <= cfg_data;
                msf_pkg::REG_PATTERN_LENGTH: pattern_length_reg <= cfg_data[msf_pkg::LEN_W-1:0];
                msf_pkg::REG_CASE_SENSITIVE: case_sensitive_reg <= cfg_data[0];
                msf_pkg::REG_GREY_OUT:       grey_out_reg       <= cfg_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (ctrl.clear) begin
                found_reg <= 1'b0;
            end else begin
                found_reg <= found_next;
            end
            if (ctrl.clear) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // hold the result payload until taken
    always_ff @(posedge aclk) begin
        if (ctrl.clear) begin
            m_payload_reg <= m_payload_next;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    `MSF_ASSERT_NEXT(a_eom_gives_result, aclk, aresetn, ctrl.clear, m_valid_reg)
    `MSF_ASSERT_NEXT(a_no_spurious_result, aclk, aresetn,
        !ctrl.clear && !(m_valid_reg && !m_ready), !m_valid_reg)
    `MSF_ASSERT_NEXT(a_eom_clears_state, aclk, aresetn, ctrl.clear,
        !found_reg && !filled_chain[1])
    `MSF_ASSERT_NOW(a_grey_needs_visible, aclk, aresetn,
        m_valid_reg && m_payload_reg.greyed_out, m_payload_reg.visible && grey_out_reg)
    `MSF_ASSERT_NOW(a_hit_needs_fill, aclk, aresetn, hit,
        filled_chain[eff_len - msf_pkg::LEN_W'(1)] || (eff_len == msf_pkg::LEN_W'(1)))

endmodule

FILE: tb/msf_result_checker.sv
`timescale 1ns / 100ps

module msf_result_checker
    import msf_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    input  logic                  s_ready,
    input  s_payload_t            s_payload,
    input  logic                  m_valid,
    input  logic                  m_ready,
    input  m_payload_t            m_payload,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int unsigned           results_due,
    output int unsigned           mismatch_count
);

    localparam int WINDOW = MAX_PATTERN_DEF;

    logic [31:0]            type_mask;
    pattern_t               pattern;
    logic [LEN_W-1:0]       pattern_length;
    logic                   case_sensitive;
    logic                   grey_out;

    // element 0 holds the newest byte
    logic [WINDOW-1:0][7:0] window;
    int unsigned            bytes_seen;
    logic                   found;
    m_payload_t             verdicts_due[$];
    int unsigned            errors;

    function automatic logic [7:0] fold_case(input logic [7:0] c, input logic exact);
        if (!exact && c >= 8'h41 && c <= 8'h5A) begin
            return c + 8'h20;
        end
        return c;
    endfunction

    task automatic take_beat(input s_payload_t b);
        int unsigned len;
        int unsigned i;
        logic        hit;
        logic        filtered;
        m_payload_t  v;
        len = (pattern_length > WINDOW) ? WINDOW : pattern_length;
        if (b.byte_valid) begin
            window = {window[WINDOW-2:0], b.text_byte};
            if (bytes_seen < WINDOW) begin
                bytes_seen++;
            end
            if (len > 0 && bytes_seen >= len) begin
                hit = 1'b1;
                // oldest byte of the compared span lines up with pattern byte 0
                for (i = 0; i < len; i++) begin
                    if (fold_case(window[len-1-i], case_sensitive) !=
                        fold_case(pattern[i], case_sensitive)) begin
                        hit = 1'b0;
                    end
                end
                if (hit) begin
                    found = 1'b1;
                end
            end
        end
        if (b.end_of_message) begin
            filtered = (int'(b.msg_type) >= TYPE_COUNT_DEF) || !type_mask[b.msg_type] ||
                       (len > 0 && !found);
            v.visible    = !filtered || grey_out;
            v.greyed_out = filtered && grey_out;
            verdicts_due.push_back(v);
            window     = '0;
            bytes_seen = 0;
            found      = 1'b0;
        end
    endtask

    always @(posedge aclk) begin
        m_payload_t want;
        if (!aresetn) begin
            type_mask      = '1;
            pattern        = '0;
            pattern_length = '0;
            case_sensitive = 1'b0;
            grey_out       = 1'b0;
            window         = '0;
            bytes_seen     = 0;
            found          = 1'b0;
            errors         = 0;
            verdicts_due.delete();
        end else begin
            if (m_valid && m_ready) begin
                if (verdicts_due.size() == 0) begin
                    $error("result beat with no message end waiting: visible=%0b greyed_out=%0b",
                           m_payload.visible, m_payload.greyed_out);
                    errors++;
                end else begin
                    want = verdicts_due.pop_front();
                    if (m_payload.visible !== want.visible) begin
                        $error("visible: expected %0b, got %0b", want.visible, m_payload.visible);
                        errors++;
                    end
                    if (m_payload.greyed_out !== want.greyed_out) begin
                        $error("greyed_out: expected %0b, got %0b",
                               want.greyed_out, m_payload.greyed_out);
                        errors++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                take_beat(s_payload);
            end
            if (cfg_we) begin
                case (cfg_index)
                    REG_TYPE_MASK:      type_mask      = cfg_data[31:0];
                    REG_PATTERN_LO:     pattern[7:0]   = cfg_data;
                    REG_PATTERN_HI:     pattern[15:8]  = cfg_data;
                    REG_PATTERN_LENGTH: pattern_length = cfg_data[LEN_W-1:0];
                    REG_CASE_SENSITIVE: case_sensitive = cfg_data[0];
                    REG_GREY_OUT:       grey_out       = cfg_data[0];
                    default: ;
                endcase
            end
        end
        results_due    <= verdicts_due.size();
        mismatch_count <= errors;
    end

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 100ps

module testbench;
    import msf_pkg::*;

    localparam int ITEM_TARGET   = 2000;
    localparam int PHASE_ITEMS   = 150;
    localparam int MAX_MSG       = 40;
    localparam int IDLE_LIMIT    = 2000;
    localparam int SETTLE_CYCLES = 4;
    localparam int TAIL_CYCLES   = 8;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE = 3'd7;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    s_payload_t            s_payload = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    m_payload_t            m_payload;
    logic                  cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data  = '0;
    int unsigned           results_due;
    int unsigned           mismatch_count;

    // settings in force, kept to shape the text
    pattern_t              cur_pattern = '0;
    int unsigned           cur_len     = 0;
    logic                  cur_exact   = 1'b0;
    int unsigned           beats_sent  = 0;
    bit                    steady_send = 1'b0;

    initial begin
        forever #5 aclk = ~aclk;
    end

    message_substring_filter_core DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_payload (s_payload),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_payload (m_payload),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    msf_result_checker verdict_check (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_payload      (s_payload),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_payload      (m_payload),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data),
        .results_due    (results_due),
        .mismatch_count (mismatch_count)
    );

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic logic [7:0] pick_char();
        int unsigned r;
        logic [7:0]  edges [5];
        edges = '{8'h40, 8'h5B, 8'h60, 8'h7B, 8'hFF};
        r = $urandom_range(0, 99);
        if (r < 35) return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + 8'($urandom_range(0, 3));
        if (r < 40) return 8'h00;
        if (r < 45) return edges[$urandom_range(0, 4)];
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic bit is_letter(input logic [7:0] c);
        return (c >= 8'h41 && c <= 8'h5A) || (c >= 8'h61 && c <= 8'h7A);
    endfunction

    function automatic s_payload_t make_beat(input logic [7:0] c, input logic bv,
                                             input logic eom, input logic [TYPE_W-1:0] t);
        s_payload_t b;
        b.text_byte      = c;
        b.byte_valid     = bv;
        b.end_of_message = eom;
        b.msg_type       = t;
        return b;
    endfunction

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        @(negedge aclk);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        cfg_we    <= 1'b0;
    endtask

    task automatic set_config(input logic [31:0] mask, input logic [63:0] lo,
                              input logic [63:0] hi, input logic [LEN_W-1:0] len,
                              input logic exact, input logic grey);
        write_reg(REG_TYPE_MASK, {32'd0, mask});
        write_reg(REG_PATTERN_LO, lo);
        write_reg(REG_PATTERN_HI, hi);
        write_reg(REG_PATTERN_LENGTH, CFG_DATA_W'(len));
        write_reg(REG_CASE_SENSITIVE, CFG_DATA_W'(exact));
        write_reg(REG_GREY_OUT, CFG_DATA_W'(grey));
        cur_pattern = {hi, lo};
        cur_len     = (len > PAT_BYTES) ? PAT_BYTES : len;
        cur_exact   = exact;
    endtask

    task automatic send_beat(input s_payload_t b);
        int unsigned gap;
        gap = steady_send ? 0 : pick_gap();
        @(negedge aclk);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid   <= 1'b1;
        s_payload <= b;
        do @(posedge aclk); while (s_ready !== 1'b1);
        beats_sent++;
    endtask

    task automatic hold_sender();
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    // hold until every verdict is back, then let the pipeline settle
    task automatic drain();
        hold_sender();
        wait (results_due == 0);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic random_config(input int unsigned phase);
        logic [31:0]      mask;
        logic [LEN_W-1:0] len;
        pattern_t         p;
        logic             exact;
        logic             grey;
        int unsigned      r;
        int unsigned      i;
        for (i = 0; i < PAT_BYTES; i++) begin
            p[i] = pick_char();
        end
        r = $urandom_range(0, 9);
        mask  = (r == 0) ? 32'd0 : (r == 1) ? '1 : ($urandom | $urandom);
        r = $urandom_range(0, 9);
        len   = (r == 0) ? 5'd0 : (r == 1) ? 5'd16 : (r == 2) ? 5'($urandom_range(17, 31))
                                                             : 5'($urandom_range(1, 6));
        exact = $urandom_range(0, 1);
        grey  = $urandom_range(0, 1);
        // pin the extremes in the first phases
        if (phase == 0) begin
            mask = '1; len = 5'd16; exact = 1'b1; grey = 1'b1;
        end else if (phase == 1) begin
            mask = '0; len = 5'd0; exact = 1'b0; grey = 1'b0;
        end else if (phase == 2) begin
            len = 5'd31;
        end
        set_config(mask, p[7:0], p[15:8], len, exact, grey);
        if ($urandom_range(0, 7) == 0) begin
            write_reg(REG_SPARE, {$urandom, $urandom});
        end
    endtask

    task automatic send_random_message();
        s_payload_t  beats [MAX_MSG];
        int unsigned n;
        int unsigned r;
        int unsigned start;
        int unsigned idx;
        int unsigned i;
        logic [7:0]  c;
        r = $urandom_range(0, 9);
        n = (r < 6) ? $urandom_range(1, 12) : (r < 9) ? $urandom_range(13, 24)
                                                      : $urandom_range(25, MAX_MSG);
        for (i = 0; i < n; i++) begin
            beats[i] = make_beat(pick_char(), $urandom_range(0, 9) != 0, 1'b0,
                                 TYPE_W'($urandom_range(0, 31)));
        end
        // plant the pattern in most messages long enough to hold it
        if (cur_len > 0 && cur_len <= n && $urandom_range(0, 3) != 0) begin
            start = $urandom_range(0, n - cur_len);
            for (i = 0; i < cur_len; i++) begin
                c = cur_pattern[i];
                if (is_letter(c) && $urandom_range(0, 2) == 0 &&
                    (!cur_exact || $urandom_range(0, 7) == 0)) begin
                    c = c ^ 8'h20;
                end
                beats[start+i].text_byte  = c;
                beats[start+i].byte_valid = 1'b1;
            end
            if ($urandom_range(0, 5) == 0) begin
                idx = start + $urandom_range(0, cur_len - 1);
                beats[idx].text_byte = beats[idx].text_byte ^ 8'h01;
            end
        end
        beats[n-1].end_of_message = 1'b1;
        for (i = 0; i < n; i++) begin
            send_beat(beats[i]);
        end
    endtask

    initial begin
        int unsigned stretch;
        int unsigned stall;
        bit          calm;
        stretch = 0;
        calm    = 1'b0;
        forever begin
            if (stretch == 0) begin
                calm    = ($urandom_range(0, 3) == 0);
                stretch = $urandom_range(10, 60);
            end
            stretch--;
            stall = calm ? 0 : pick_gap();
            @(negedge aclk);
            if (stall > 0) begin
                m_ready <= 1'b0;
                repeat (stall) @(negedge aclk);
            end
            m_ready <= 1'b1;
            repeat ($urandom_range(1, 6)) @(posedge aclk);
        end
    end

    initial begin
        int unsigned quiet;
        quiet = 0;
        while (quiet < IDLE_LIMIT) begin
            @(posedge aclk);
            if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready)) begin
                quiet = 0;
            end else begin
                quiet++;
            end
        end
        $display("status: fail");
        $finish;
    end

    initial begin
        int unsigned phase;
        int unsigned target;
        int unsigned i;
        repeat (9) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // settings out of reset: every type passes, no text test
        send_beat(make_beat(8'h00, 1'b1, 1'b1, 5'd31));
        drain();

        // pattern "Ab", zero byte, "Z", folded, greyed when filtered
        set_config(32'h8000_0001, 64'h0000_0000_5A00_6241, 64'd0, 5'd4, 1'b0, 1'b1);
        write_reg(REG_SPARE, '1);
        send_beat(make_beat("Q", 1'b0, 1'b0, 5'd3));
        send_beat(make_beat("x", 1'b1, 1'b0, 5'd3));
        send_beat(make_beat("a", 1'b1, 1'b0, 5'd3));
        send_beat(make_beat("B", 1'b1, 1'b0, 5'd3));
        send_beat(make_beat(8'h00, 1'b1, 1'b0, 5'd3));
        send_beat(make_beat("z", 1'b1, 1'b1, 5'd0));

        // switch to exact compare part way through a message
        send_beat(make_beat("a", 1'b1, 1'b0, 5'd0));
        send_beat(make_beat("B", 1'b1, 1'b0, 5'd0));
        send_beat(make_beat(8'h00, 1'b1, 1'b0, 5'd0));
        drain();
        write_reg(REG_CASE_SENSITIVE, CFG_DATA_W'(1'b1));
        cur_exact = 1'b1;
        send_beat(make_beat("Z", 1'b1, 1'b1, 5'd31));
        drain();

        // over-long length clamps to a full sixteen-byte pattern
        set_config('1, 64'h80FF_7F00_5A41_617A, 64'hFEDC_BA98_7654_3210, 5'd17, 1'b1, 1'b0);
        for (i = 0; i < PAT_BYTES; i++) begin
            send_beat(make_beat(cur_pattern[i], 1'b1, i == PAT_BYTES - 1, 5'd7));
        end

        phase = 0;
        while (beats_sent < ITEM_TARGET) begin
            drain();
            random_config(phase);
            steady_send = ($urandom_range(0, 3) == 0);
            target = beats_sent + PHASE_ITEMS;
            while (beats_sent < target) begin
                send_random_message();
            end
            phase++;
        end

        hold_sender();
        wait (results_due == 0);
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
